### rtl/core/acle_pkg.sv
// ----------------------------------------------------------------------------
// acle_pkg : shared types and constants for the AT command line editor
// Line store geometry, configuration register indexes, result codes and the
// transaction structs of the input and result channels.
// ----------------------------------------------------------------------------
package acle_pkg;

  // Line store geometry: two banks of LINE_DEPTH bytes
  localparam int LINE_DEPTH = 256;
  localparam int MEM_DEPTH  = 2 * LINE_DEPTH;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int POS_W      = $clog2(LINE_DEPTH + 1);
  localparam int LIMIT_W    = 9;
  localparam int CMP_W      = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;
  localparam int IDX_W      = (ADDR_W > 8) ? ADDR_W : 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_FEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd4;

  // Configuration reset values
  localparam logic [7:0]         RST_LINE_FEED = 8'd10;
  localparam logic [7:0]         RST_BACKSPACE = 8'd8;
  localparam logic [LIMIT_W-1:0] RST_LIMIT     = 9'd256;

  // Fixed echo codes for a backspace
  localparam logic [7:0] ECHO_BS    = 8'h08;
  localparam logic [7:0] ECHO_SPACE = 8'h20;

  // Result kinds
  localparam logic [2:0] KIND_ECHO      = 3'd0;
  localparam logic [2:0] KIND_LINE_DONE = 3'd1;
  localparam logic [2:0] KIND_DATA      = 3'd2;
  localparam logic [2:0] KIND_LINE_BYTE = 3'd3;
  localparam logic [2:0] KIND_RANGE     = 3'd4;

  // Input transaction
  typedef struct packed {
    logic       mode;
    logic [7:0] byte_in;
    logic       last_in_chunk;
    logic [7:0] read_index;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] result_byte;
    logic [8:0] line_length;
    logic       chunk_end;
    logic       last;
  } out_item_t;

  // Result sequence an accepted transaction turns into
  typedef enum logic [2:0] {
    JOB_BS3,
    JOB_ECHO,
    JOB_ECHO_DONE,
    JOB_DONE,
    JOB_DATA,
    JOB_READ,
    JOB_RANGE
  } job_kind_t;

  typedef struct packed {
    job_kind_t  jkind;
    logic [7:0] jbyte;
    logic [8:0] jlength;
    logic       jchunk_end;
  } job_t;

endpackage

### rtl/core/at_command_line_editor_core.sv
// ----------------------------------------------------------------------------
// at_command_line_editor_core : AT command line editor
// Line editing over a two-bank line store with echo, backspace and bank swap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries received bytes
//   (mode 0) or command-line read requests (mode 1). Result channel
//   (out_valid / out_stall / out_data) returns echo, line-done, data,
//   line-byte and out-of-range transactions; the final one of each input
//   has last set. Configuration is written through cfg_we / cfg_index /
//   cfg_wdata while the block is idle.
//   The first result goes from the job slot through the output register.
//   Throughput: one input per cycle while each input gives at most one
//   result and the output is not stalled; an input with two or three
//   results holds the job slot while the sequencer emits one result per
//   cycle. Editing state is updated at acceptance; stored bytes are written
//   into the line memory at that edge and reads get the registered memory
//   port the same edge, so writes and reads of one entry never overlap.
//   Reset (synchronous, rst_n low) restores the configuration defaults and
//   empties the line; the line memory itself is not cleared and needs no
//   clearing pass. A stalled receiver holds the output register; the
//   sequencer keeps its job and in_stall rises until the job can finish.
// ----------------------------------------------------------------------------
module at_command_line_editor_core
  import acle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  // Configuration registers
  logic [7:0]         line_feed_r;
  logic [7:0]         backspace_r;
  logic               echo_r;
  logic               cmd_mode_r;
  logic [LIMIT_W-1:0] limit_r;

  // Editing state
  logic             edit_bank_r, edit_bank_nxt;
  logic [POS_W-1:0] edit_pos_r, edit_pos_nxt;
  logic [POS_W-1:0] cmd_len_r, cmd_len_nxt;
  logic             discard_r, discard_nxt;

  // Line memory
  logic [7:0] line_mem [MEM_DEPTH];
  logic [7:0] rd_byte_r;
  logic       mem_we;
  logic       mem_re;
  logic [ADDR_W:0] waddr;
  logic [ADDR_W:0] raddr;

  logic       in_accept;
  logic       job_free;
  logic       job_load;
  job_t       job;
  logic [CMP_W-1:0] limit_eff;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] len_ext;
  logic [IDX_W-1:0] ridx_ext;

  assign in_stall  = !job_free;
  assign in_accept = in_valid && job_free;

  // Effective limit is the smaller of the register and the bank depth
  assign limit_eff = (CMP_W'(limit_r) > CMP_W'(LINE_DEPTH)) ? CMP_W'(LINE_DEPTH)
                                                            : CMP_W'(limit_r);
  assign pos_ext   = CMP_W'(edit_pos_r);
  assign len_ext   = CMP_W'(cmd_len_r);
  assign ridx_ext  = IDX_W'(in_data.read_index);

  assign waddr = {edit_bank_r, edit_pos_r[ADDR_W-1:0]};
  assign raddr = {~edit_bank_r, ridx_ext[ADDR_W-1:0]};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_feed_r <= RST_LINE_FEED;
      backspace_r <= RST_BACKSPACE;
      echo_r      <= 1'b1;
      cmd_mode_r  <= 1'b1;
      limit_r     <= RST_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_FEED: line_feed_r <= cfg_wdata[7:0];
        CFG_BACKSPACE: backspace_r <= cfg_wdata[7:0];
        CFG_ECHO:      echo_r      <= cfg_wdata[0];
        CFG_CMD_MODE:  cmd_mode_r  <= cfg_wdata[0];
        CFG_LIMIT:     limit_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decode of an accepted transaction: state update, memory access, job
  always_comb begin
    edit_bank_nxt  = edit_bank_r;
    edit_pos_nxt   = edit_pos_r;
    cmd_len_nxt    = cmd_len_r;
    discard_nxt    = discard_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    job_load       = 1'b0;
    job.jkind      = JOB_ECHO;
    job.jbyte      = in_data.byte_in;
    job.jlength    = 9'(edit_pos_r);
    job.jchunk_end = in_data.last_in_chunk;
    if (in_accept) begin
      priority if (in_data.mode) begin
        mem_re    = 1'b1;
        job_load  = 1'b1;
        job.jkind = (CMP_W'(ridx_ext) < len_ext) ? JOB_READ : JOB_RANGE;
      end else if (!cmd_mode_r) begin
        job_load  = 1'b1;
        job.jkind = JOB_DATA;
      end else if (discard_r) begin
        if (in_data.last_in_chunk) begin
          discard_nxt = 1'b0;
        end
      end else if (in_data.byte_in == backspace_r) begin
        if (edit_pos_r != '0) begin
          edit_pos_nxt = edit_pos_r - POS_W'(1);
        end
        job_load  = echo_r;
        job.jkind = JOB_BS3;
      end else if (pos_ext >= limit_eff) begin
        // overflow: restart the line, drop the rest of the chunk
        edit_pos_nxt = '0;
        discard_nxt  = !in_data.last_in_chunk;
      end else if (in_data.byte_in == line_feed_r) begin
        if (edit_pos_r == '0) begin
          job_load  = echo_r;
          job.jkind = JOB_ECHO;
        end else begin
          // line complete: swap banks
          cmd_len_nxt   = edit_pos_r;
          edit_bank_nxt = ~edit_bank_r;
          edit_pos_nxt  = '0;
          job_load      = 1'b1;
          job.jkind     = echo_r ? JOB_ECHO_DONE : JOB_DONE;
        end
      end else begin
        mem_we       = 1'b1;
        edit_pos_nxt = edit_pos_r + POS_W'(1);
        job_load     = echo_r;
        job.jkind    = JOB_ECHO;
      end
    end
  end

  // Editing state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edit_bank_r <= 1'b0;
      edit_pos_r  <= '0;
      cmd_len_r   <= '0;
      discard_r   <= 1'b0;
    end else begin
      edit_bank_r <= edit_bank_nxt;
      edit_pos_r  <= edit_pos_nxt;
      cmd_len_r   <= cmd_len_nxt;
      discard_r   <= discard_nxt;
    end
  end

  // Line memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[waddr] <= in_data.byte_in;
    end
    if (mem_re) begin
      rd_byte_r <= line_mem[raddr];
    end
  end

  // Result sequencer
  acle_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_load  (job_load),
    .job_in    (job),
    .rd_byte   (rd_byte_r),
    .job_free  (job_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(edit_pos_r) <= CMP_W'(LINE_DEPTH))
    else $error("edit position beyond line depth");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cmd_len_r) <= CMP_W'(LINE_DEPTH))
    else $error("command length beyond line depth");

  a_discard_empty: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> (edit_pos_r == '0))
    else $error("discarding with a partly filled line");

  a_store_in_bank: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (pos_ext < limit_eff) && !mem_re)
    else $error("line store write out of range");

endmodule

### rtl/core/acle_emit.sv
// ----------------------------------------------------------------------------
// acle_emit : result sequencer
// Holds one decoded job and plays out its one to three results, one per
// cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module acle_emit
  import acle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_load,
  input  job_t      job_in,
  input  logic [7:0] rd_byte,
  output logic      job_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      job_valid_r;
  job_t      job_r;
  logic [1:0] step_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      out_load;
  logic      emit;
  logic      final_step;
  out_item_t cur;

  assign out_load = !out_valid_r || !out_stall;
  assign emit     = job_valid_r && out_load;
  assign job_free = !job_valid_r || (emit && final_step);

  // Result for the current step of the job
  always_comb begin
    cur        = '0;
    final_step = 1'b1;
    unique case (job_r.jkind)
      JOB_BS3: begin
        cur.kind        = KIND_ECHO;
        cur.result_byte = (step_r == 2'd1) ? ECHO_SPACE : ECHO_BS;
        final_step      = (step_r == 2'd2);
      end
      JOB_ECHO: begin
        cur.kind        = KIND_ECHO;
        cur.result_byte = job_r.jbyte;
      end
      JOB_ECHO_DONE: begin
        final_step = (step_r == 2'd1);
        if (step_r == 2'd0) begin
          cur.kind        = KIND_ECHO;
          cur.result_byte = job_r.jbyte;
        end else begin
          cur.kind        = KIND_LINE_DONE;
          cur.line_length = job_r.jlength;
        end
      end
      JOB_DONE: begin
        cur.kind        = KIND_LINE_DONE;
        cur.line_length = job_r.jlength;
      end
      JOB_DATA: begin
        cur.kind        = KIND_DATA;
        cur.result_byte = job_r.jbyte;
        cur.chunk_end   = job_r.jchunk_end;
      end
      JOB_READ: begin
        cur.kind        = KIND_LINE_BYTE;
        cur.result_byte = rd_byte;
      end
      JOB_RANGE: begin
        cur.kind = KIND_RANGE;
      end
      default: begin
        cur.kind = KIND_RANGE;
      end
    endcase
    cur.last = final_step;
  end

  // Job slot and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      step_r      <= 2'd0;
    end else if (job_load) begin
      job_valid_r <= 1'b1;
      step_r      <= 2'd0;
    end else if (emit && final_step) begin
      job_valid_r <= 1'b0;
    end else if (emit) begin
      step_r <= step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= job_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench : self-checking bench for the AT command line editor core
// Feeds received bytes and command-line reads through the valid/stall input
// channel. A local line-editor model predicts every echo, line-done, data,
// line-byte and out-of-range transaction, and the monitor checks each result
// against it field by field. Runs a directed part, then random sessions under
// several register settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  import acle_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 8;
  localparam int PHASES      = 12;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  at_command_line_editor_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Register mirror, reset values
  logic [7:0]         lf_char = RST_LINE_FEED;
  logic [7:0]         bs_char = RST_BACKSPACE;
  logic               echo_on = 1'b1;
  logic               cmd_on  = 1'b1;
  logic [LIMIT_W-1:0] line_cap = RST_LIMIT;

  // Editor state mirror
  logic [7:0] line_store [2*LINE_DEPTH];
  int         edit_bank    = 0;
  int         edit_pos     = 0;
  int         cmd_len      = 0;
  logic       discard_rest = 1'b0;

  in_item_t  rx_q[$];     // bytes and reads waiting to be sent
  out_item_t reply_q[$];  // replies the editor owes
  int        rx_pushed   = 0;
  int        rx_accepted = 0;
  int        errors      = 0;
  int        send_gap_pct = 0;
  int        stall_pct    = 0;
  int        quiet        = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_item_t make_reply(input logic [2:0] k, input logic [7:0] b,
                                           input int len, input logic ce);
    out_item_t r;
    r.kind        = k;
    r.result_byte = b;
    r.line_length = len[8:0];
    r.chunk_end   = ce;
    r.last        = 1'b0;
    return r;
  endfunction

  // Line editor: update state for one accepted transaction, queue its replies
  task automatic edit_and_reply(input in_item_t it);
    out_item_t r[$];
    int        lim;
    lim = (line_cap < LINE_DEPTH) ? int'(line_cap) : LINE_DEPTH;
    if (it.mode) begin
      if (it.read_index < cmd_len)
        r.push_back(make_reply(KIND_LINE_BYTE,
                               line_store[(edit_bank ^ 1) * LINE_DEPTH + it.read_index],
                               0, 1'b0));
      else
        r.push_back(make_reply(KIND_RANGE, 8'd0, 0, 1'b0));
    end else if (!cmd_on) begin
      r.push_back(make_reply(KIND_DATA, it.byte_in, 0, it.last_in_chunk));
    end else if (discard_rest) begin
      // rest of an overflowed chunk is swallowed
      if (it.last_in_chunk) discard_rest = 1'b0;
    end else if (it.byte_in == bs_char) begin
      if (edit_pos > 0) edit_pos--;
      if (echo_on) begin
        r.push_back(make_reply(KIND_ECHO, ECHO_BS, 0, 1'b0));
        r.push_back(make_reply(KIND_ECHO, ECHO_SPACE, 0, 1'b0));
        r.push_back(make_reply(KIND_ECHO, ECHO_BS, 0, 1'b0));
      end
    end else if (edit_pos >= lim) begin
      edit_pos     = 0;
      discard_rest = !it.last_in_chunk;
    end else if (edit_pos == 0 && it.byte_in == lf_char) begin
      if (echo_on) r.push_back(make_reply(KIND_ECHO, it.byte_in, 0, 1'b0));
    end else begin
      if (echo_on) r.push_back(make_reply(KIND_ECHO, it.byte_in, 0, 1'b0));
      if (it.byte_in == lf_char) begin
        // bank swap: the edited bank becomes the command line
        cmd_len = edit_pos;
        r.push_back(make_reply(KIND_LINE_DONE, 8'd0, cmd_len, 1'b0));
        edit_bank = edit_bank ^ 1;
        edit_pos  = 0;
      end else begin
        line_store[edit_bank * LINE_DEPTH + edit_pos] = it.byte_in;
        edit_pos++;
      end
    end
    if (r.size() > 0) r[r.size()-1].last = 1'b1;
    foreach (r[k]) reply_q.push_back(r[k]);
  endtask

  // Driver: present queued transactions, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        edit_and_reply(in_data);
        rx_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= rx_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic check_field(input string name, input logic [8:0] want,
                             input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Monitor: compare each result transaction with the oldest reply owed
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result transaction: kind %0d byte %0d",
               out_data.kind, out_data.result_byte);
        errors++;
      end else begin
        want = reply_q.pop_front();
        check_field("kind",        9'(want.kind),        9'(out_data.kind));
        check_field("result_byte", 9'(want.result_byte), 9'(out_data.result_byte));
        check_field("line_length", want.line_length,     out_data.line_length);
        check_field("chunk_end",   9'(want.chunk_end),   9'(out_data.chunk_end));
        check_field("last",        9'(want.last),        9'(out_data.last));
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic in_item_t rx_item(input logic m, input logic [7:0] ch,
                                       input logic lic, input logic [7:0] idx);
    in_item_t it;
    it.mode          = m;
    it.byte_in       = ch;
    it.last_in_chunk = lic;
    it.read_index    = idx;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    rx_q.push_back(it);
    rx_pushed++;
  endtask

  // A character that neither ends nor edits the line
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == lf_char || c == bs_char) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[LIMIT_W-1:0];
    case (idx)
      CFG_LINE_FEED: lf_char  = value[7:0];
      CFG_BACKSPACE: bs_char  = value[7:0];
      CFG_ECHO:      echo_on  = value[0];
      CFG_CMD_MODE:  cmd_on   = value[0];
      CFG_LIMIT:     line_cap = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int lf, input int bs, input int echo,
                           input int cmd, input int cap);
    write_reg(CFG_LINE_FEED, lf);
    write_reg(CFG_BACKSPACE, bs);
    write_reg(CFG_ECHO, echo);
    write_reg(CFG_CMD_MODE, cmd);
    write_reg(CFG_LIMIT, cap);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until everything sent has been answered, then let the core settle
  task automatic drain();
    while (rx_accepted != rx_pushed || reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Idling pattern by phase: stalled receiver, then slow sender, then neither
  task automatic set_idling(input int phase);
    case (phase * 3 / PHASES)
      0:       begin send_gap_pct = 10; stall_pct = 60; end
      1:       begin send_gap_pct = 60; stall_pct = 10; end
      default: begin send_gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic random_settings();
    int lf, bs, cap;
    case ($urandom_range(0, 3))
      0: lf = 10;
      1: lf = 0;
      2: lf = 255;
      default: lf = int'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0: bs = 8;
      1: bs = 0;
      2: bs = 255;
      default: bs = int'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 6))
      0: cap = int'($urandom_range(1, 4));
      1: cap = int'($urandom_range(5, 12));
      2: cap = int'($urandom_range(1, 12));
      3: cap = 256;
      4: cap = 511;
      5: cap = 0;
      default: cap = 255;
    endcase
    configure(lf, bs, int'($urandom_range(0, 1)), int'($urandom_range(0, 4) != 0), cap);
  endtask

  // Mostly well-formed lines with edits, then reads; some noise
  task automatic random_session(input int n);
    int made, sel, len, reads;
    made = 0;
    while (made < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        len = $urandom_range(0, 10);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 6) == 0)
            send(rx_item(1'b0, bs_char, $urandom_range(0, 7) == 0, 8'($urandom)));
          else
            send(rx_item(1'b0, plain_char(), $urandom_range(0, 7) == 0, 8'($urandom)));
        end
        send(rx_item(1'b0, lf_char, 1'($urandom_range(0, 1)), 8'($urandom)));
        reads = $urandom_range(0, 3);
        for (int k = 0; k < reads; k++)
          send(rx_item(1'b1, 8'($urandom), 1'($urandom), 8'($urandom_range(0, 11))));
        made += len + 1 + reads;
      end else if (sel < 85) begin
        send(rx_item(1'b1, 8'($urandom), 1'($urandom), 8'($urandom_range(0, 255))));
        made++;
      end else begin
        send(rx_item(1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom)));
        made++;
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: field extremes, backspace, line done, reads, empty line feed
    set_idling(0);
    @(posedge clk);
    send(rx_item(1'b0, 8'h41, 1'b0, 8'd0));
    send(rx_item(1'b0, 8'h00, 1'b0, 8'd0));
    send(rx_item(1'b0, 8'hFF, 1'b1, 8'd255));
    send(rx_item(1'b0, RST_BACKSPACE, 1'b0, 8'd0));
    send(rx_item(1'b0, RST_LINE_FEED, 1'b1, 8'd0));
    send(rx_item(1'b1, 8'h00, 1'b0, 8'd0));
    send(rx_item(1'b1, 8'hFF, 1'b1, 8'd1));
    send(rx_item(1'b1, 8'h00, 1'b0, 8'd2));
    send(rx_item(1'b1, 8'h00, 1'b0, 8'd255));
    send(rx_item(1'b0, RST_LINE_FEED, 1'b0, 8'd0));
    send(rx_item(1'b0, RST_BACKSPACE, 1'b0, 8'd0));
    drain();

    // Small limit, echo off: overflow, discard to chunk end, silent edits
    set_idling(1);
    configure(255, 0, 0, 1, 2);
    send(rx_item(1'b0, 8'h61, 1'b0, 8'd0));
    send(rx_item(1'b0, 8'h62, 1'b0, 8'd0));
    send(rx_item(1'b0, 8'h63, 1'b0, 8'd0));
    send(rx_item(1'b0, 8'h64, 1'b0, 8'd0));
    send(rx_item(1'b0, 8'h00, 1'b1, 8'd0));
    send(rx_item(1'b0, 8'h78, 1'b0, 8'd0));
    send(rx_item(1'b0, 8'hFF, 1'b0, 8'd0));
    send(rx_item(1'b0, 8'h00, 1'b0, 8'd0));
    send(rx_item(1'b0, 8'hFF, 1'b0, 8'd0));
    send(rx_item(1'b1, 8'h00, 1'b0, 8'd0));
    drain();

    // Zero limit, line feed equal to backspace
    set_idling(2);
    configure(8'h55, 8'h55, 1, 1, 0);
    send(rx_item(1'b0, 8'h55, 1'b0, 8'd0));
    send(rx_item(1'b0, 8'h71, 1'b1, 8'd0));
    drain();

    // Data pass-through, limit above the store depth
    set_idling(3);
    configure(10, 8, 1, 0, 511);
    send(rx_item(1'b0, 8'hFF, 1'b1, 8'd0));
    send(rx_item(1'b0, 8'h00, 1'b0, 8'd0));
    drain();

    // Random sessions
    for (int p = 4; p < PHASES; p++) begin
      set_idling(p);
      random_settings();
      random_session(29);
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### files.f
rtl/core/acle_pkg.sv
rtl/core/acle_emit.sv
rtl/core/at_command_line_editor_core.sv
tb/testbench.sv
